### rtl/rgb_conv2d_valid_saturate_defines.svh
// ============================================================================
// rgb_conv2d_valid_saturate_defines.svh
// Assertion macros shared by the convolution block; empty when SYNTH is set.
// ============================================================================
`ifndef RGB_CONV2D_VALID_SATURATE_DEFINES_SVH
`define RGB_CONV2D_VALID_SATURATE_DEFINES_SVH
`ifndef SYNTH
// Condition must hold at every edge out of reset.
`define RCV_ASSERT_HOLD(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rcv check failed");
// Consequent must hold in the cycle after the antecedent.
`define RCV_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rcv check failed");
`else
`define RCV_ASSERT_HOLD(lbl, cond)
`define RCV_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### rtl/rcv_pkg.sv
// ============================================================================
// rcv_pkg
// Beat types, widths and codes of the streaming RGB convolution block.
// ============================================================================
package rcv_pkg;

    localparam int PIX_W      = 24;
    localparam int CH_W       = 8;
    localparam int CHANNELS   = 3;
    localparam int WGT_W      = 8;
    localparam int PROD_W     = 17;  // signed 8 bits times unsigned 8 bits
    localparam int BIAS_W     = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CH_W-1:0] CLAMP_MAX = 8'd255;

    // Input beat codes
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_PIXEL  = 1'b1;

    // Register index, taken from paddr[2]
    localparam logic REG_BIAS = 1'b0;

    typedef struct packed {
        logic                    opcode;
        logic [3:0]              weight_index;
        logic signed [WGT_W-1:0] weight_value;
        logic [PIX_W-1:0]        pixel_in;
        logic                    frame_end;
    } item_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             last_out;
    } result_t;

    // Control that travels down the pipeline next to each beat
    typedef struct packed {
        logic valid;
        logic is_pixel;
        logic win;
        logic last;
    } tag_t;

endpackage

### rtl/rcv_line_mem.sv
// ============================================================================
// rcv_line_mem
// Line buffer memory: one word per column holds the buffered rows.
// ============================================================================
module rcv_line_mem #(
    parameter int DEPTH  = 32,
    parameter int WORD_W = 48,
    parameter int ADDR_W = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] mem_q_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic              fwd_reg;
    logic              fwd_hit;

    // A read that lands on the column being written in the same cycle
    // sees stale data; bypass it.
    assign fwd_hit = rd_en && wr_en && (rd_addr == wr_addr);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_reg <= fwd_hit;
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : mem_q_reg;

endmodule

### rtl/rcv_mac.sv
// ============================================================================
// rcv_mac
// Window registers, kernel weights and the per-tap channel products.
// ============================================================================
module rcv_mac import rcv_pkg::*; #(
    parameter int KSIZE = 3
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          adv,
    input  tag_t                                          s1_tag,
    input  logic [KSIZE-1:0][PIX_W-1:0]                   col_vec,
    input  logic [3:0]                                    wt_idx,
    input  logic signed [WGT_W-1:0]                       wt_val,
    output tag_t                                          s3_tag,
    output logic [KSIZE*KSIZE-1:0][CHANNELS-1:0][PROD_W-1:0] prod
);

    localparam int KAREA = KSIZE * KSIZE;

    logic [KSIZE-1:0][KSIZE-1:0][PIX_W-1:0]          win_reg;
    logic signed [WGT_W-1:0]                         kern_reg [KAREA];
    logic [KAREA-1:0][CHANNELS-1:0][PROD_W-1:0]      prod_next;
    logic [KAREA-1:0][CHANNELS-1:0][PROD_W-1:0]      prod_reg;
    tag_t                                            s2_tag_reg;
    tag_t                                            s3_tag_reg;

    // Shift the window left and load the new column on the right.
    always_ff @(posedge clk)
    begin
        if (adv && s1_tag.valid && s1_tag.is_pixel)
        begin
            for (int r = 0; r < KSIZE; r++)
            begin
                for (int x = 0; x < KSIZE - 1; x++)
                begin
                    win_reg[r][x] <= win_reg[r][x+1];
                end
                win_reg[r][KSIZE-1] <= col_vec[r];
            end
        end
    end

    // Weight beats write at this stage so they order correctly against pixels.
    always_ff @(posedge clk)
    begin
        if (adv && s1_tag.valid && !s1_tag.is_pixel)
        begin
            for (int i = 0; i < KAREA; i++)
            begin
                if (int'(wt_idx) == i)
                begin
                    kern_reg[i] <= wt_val;
                end
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < KSIZE; r++)
        begin
            for (int x = 0; x < KSIZE; x++)
            begin
                for (int ch = 0; ch < CHANNELS; ch++)
                begin
                    prod_next[r*KSIZE+x][ch] =
                        $signed({{(PROD_W-WGT_W){kern_reg[r*KSIZE+x][WGT_W-1]}},
                                 kern_reg[r*KSIZE+x]}) *
                        $signed({{(PROD_W-CH_W){1'b0}}, win_reg[r][x][ch*CH_W +: CH_W]});
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
        end
        else if (adv)
        begin
            s2_tag_reg <= s1_tag;
            s3_tag_reg <= s2_tag_reg;
        end
    end

    assign s3_tag = s3_tag_reg;
    assign prod   = prod_reg;

endmodule

### rtl/rcv_sum.sv
// ============================================================================
// rcv_sum
// Adder tree over the kernel taps, bias add, clamp and result register.
// ============================================================================
module rcv_sum import rcv_pkg::*; #(
    parameter int KSIZE = 3
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             adv,
    input  tag_t                                             s3_tag,
    input  logic [KSIZE*KSIZE-1:0][CHANNELS-1:0][PROD_W-1:0] prod,
    input  logic signed [BIAS_W-1:0]                         bias,
    output logic                                             res_valid,
    output result_t                                          res
);

    localparam int KAREA = KSIZE * KSIZE;
    localparam int SUM_W = PROD_W + $clog2(KSIZE) + 1;
    localparam int ACC_W = SUM_W + $clog2(KSIZE) + 2;

    logic [KSIZE-1:0][CHANNELS-1:0][SUM_W-1:0] row_next;
    logic [KSIZE-1:0][CHANNELS-1:0][SUM_W-1:0] row_reg;
    tag_t                                      s4_tag_reg;
    logic [PIX_W-1:0]                          pix_next;
    logic                                      res_valid_reg;
    result_t                                   res_reg;

    // First level: sum each kernel row.
    always_comb
    begin
        logic signed [SUM_W-1:0] acc;
        for (int r = 0; r < KSIZE; r++)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                acc = '0;
                for (int x = 0; x < KSIZE; x++)
                begin
                    acc = acc + SUM_W'($signed(prod[r*KSIZE+x][ch]));
                end
                row_next[r][ch] = acc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            row_reg <= row_next;
        end
    end

    // Second level: rows plus bias, then clamp to a byte.
    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        pix_next = '0;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            acc = ACC_W'(bias);
            for (int r = 0; r < KSIZE; r++)
            begin
                acc = acc + ACC_W'($signed(row_reg[r][ch]));
            end
            if (acc < 0)
            begin
                pix_next[ch*CH_W +: CH_W] = '0;
            end
            else if (acc > ACC_W'(CLAMP_MAX))
            begin
                pix_next[ch*CH_W +: CH_W] = CLAMP_MAX;
            end
            else
            begin
                pix_next[ch*CH_W +: CH_W] = acc[CH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_tag_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s4_tag_reg    <= s3_tag;
            res_valid_reg <= s4_tag_reg.valid && s4_tag_reg.is_pixel && s4_tag_reg.win;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg.pixel_out <= pix_next;
            res_reg.last_out  <= s4_tag_reg.last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

### rtl/rgb_conv2d_valid_saturate.sv
// ============================================================================
// rgb_conv2d_valid_saturate
// Streaming KxK convolution of RGB pixels, valid windows, clamped to bytes.
// ============================================================================
// The block takes one beat per clock when not stalled: a pixel beat in
// raster order or a weight beat that loads one signed kernel tap. Each pixel
// is pushed through a line buffer memory holding the previous KSIZE-1 rows
// (one word per column, read on accept and written back from stage 1 when
// the pipeline next advances, with a bypass when consecutive pixels hit the
// same column) and into a KxK window. When the bottom-right pixel of a
// complete window arrives, the block adds the bias to the sum of weight times
// byte for red, green and blue, clamps each to 0..255 and returns one result
// beat; last_out marks the window ending at the last row and column of the
// frame. A frame_end pixel returns the frame position to the top-left corner.
// Throughput is one beat per clock while not stalled; a result passes line read,
// window load, products, row sums, and bias and clamp into the result register.
// The input stalls only while the result register holds a beat that is stalled.
// The bias register sits at byte address 0 of the APB port; the line memory
// needs no clearing after reset and the kernel must be loaded before use.
// ============================================================================
`include "rgb_conv2d_valid_saturate_defines.svh"

module rgb_conv2d_valid_saturate import rcv_pkg::*; #(
    parameter int IMG_WIDTH  = 32,
    parameter int IMG_HEIGHT = 32,
    parameter int KSIZE      = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // pixel and weight beats
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    // result beats
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int COL_W = (IMG_WIDTH > 1) ? $clog2(IMG_WIDTH) : 1;
    localparam int ROW_W = (IMG_HEIGHT > 1) ? $clog2(IMG_HEIGHT) : 1;
    localparam int LROWS = (KSIZE > 1) ? KSIZE - 1 : 1;
    localparam int KAREA = KSIZE * KSIZE;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(IMG_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(IMG_HEIGHT - 1);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic signed [BIAS_W-1:0] bias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_BIAS))
        begin
            bias_reg <= pwdata[BIAS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BIAS) ? CFG_DATA_W'(bias_reg) : '0;

    // ------------------------------------------------------------------
    // Accept and frame position
    // ------------------------------------------------------------------
    logic             adv;
    logic             item_accept;
    logic             pix_accept;
    logic [COL_W-1:0] pos_col_reg;
    logic [COL_W-1:0] pos_col_next;
    logic [ROW_W-1:0] pos_row_reg;
    logic [ROW_W-1:0] pos_row_next;
    logic             win_now;
    logic             last_now;
    logic             res_valid;
    result_t          res;

    // The whole pipeline moves together; hold it only while a result is
    // stuck in the output register.
    assign adv         = !(res_valid && result_stall);
    assign item_stall  = !adv;
    assign item_accept = item_valid && adv;
    assign pix_accept  = item_accept && (item.opcode == OP_PIXEL);

    assign win_now  = (int'(pos_row_reg) >= KSIZE - 1) && (int'(pos_col_reg) >= KSIZE - 1);
    assign last_now = win_now && (pos_row_reg == ROW_LAST) && (pos_col_reg == COL_LAST);

    always_comb
    begin
        pos_col_next = pos_col_reg;
        pos_row_next = pos_row_reg;
        if (pix_accept)
        begin
            if (item.frame_end)
            begin
                pos_col_next = '0;
                pos_row_next = '0;
            end
            else if (pos_col_reg == COL_LAST)
            begin
                pos_col_next = '0;
                pos_row_next = (pos_row_reg == ROW_LAST) ? '0 : pos_row_reg + 1'b1;
            end
            else
            begin
                pos_col_next = pos_col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_col_reg <= '0;
            pos_row_reg <= '0;
        end
        else
        begin
            pos_col_reg <= pos_col_next;
            pos_row_reg <= pos_row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line memory read returns, build the new window column
    // ------------------------------------------------------------------
    tag_t                    s1_tag_reg;
    logic [PIX_W-1:0]        s1_pix_reg;
    logic [COL_W-1:0]        s1_col_reg;
    logic [3:0]              s1_widx_reg;
    logic signed [WGT_W-1:0] s1_wval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
        end
        else if (adv)
        begin
            s1_tag_reg.valid    <= item_accept;
            s1_tag_reg.is_pixel <= item.opcode == OP_PIXEL;
            s1_tag_reg.win      <= win_now;
            s1_tag_reg.last     <= last_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_pix_reg  <= item.pixel_in;
            s1_col_reg  <= pos_col_reg;
            s1_widx_reg <= item.weight_index;
            s1_wval_reg <= item.weight_value;
        end
    end

    logic [LROWS-1:0][PIX_W-1:0] rd_word;
    logic [LROWS-1:0][PIX_W-1:0] wr_word;
    logic [KSIZE-1:0][PIX_W-1:0] col_vec;
    logic                        line_wr;

    // Column is oldest row first; each buffered row moves up by one.
    always_comb
    begin
        wr_word = '0;
        col_vec[KSIZE-1] = s1_pix_reg;
        for (int r = 0; r < KSIZE - 1; r++)
        begin
            col_vec[r] = rd_word[r];
        end
        for (int r = 0; r < KSIZE - 1; r++)
        begin
            wr_word[r] = col_vec[r+1];
        end
    end

    assign line_wr = adv && s1_tag_reg.valid && s1_tag_reg.is_pixel;

    rcv_line_mem #(
        .DEPTH  (IMG_WIDTH),
        .WORD_W (LROWS * PIX_W),
        .ADDR_W (COL_W)
    ) u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (pix_accept),
        .rd_addr (pos_col_reg),
        .rd_data (rd_word),
        .wr_en   (line_wr),
        .wr_addr (s1_col_reg),
        .wr_data (wr_word)
    );

    // ------------------------------------------------------------------
    // Stages 2 to 5: window, products, sums, clamp
    // ------------------------------------------------------------------
    tag_t                                      s3_tag;
    logic [KAREA-1:0][CHANNELS-1:0][PROD_W-1:0] prod;

    rcv_mac #(
        .KSIZE (KSIZE)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .s1_tag  (s1_tag_reg),
        .col_vec (col_vec),
        .wt_idx  (s1_widx_reg),
        .wt_val  (s1_wval_reg),
        .s3_tag  (s3_tag),
        .prod    (prod)
    );

    rcv_sum #(
        .KSIZE (KSIZE)
    ) u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .s3_tag    (s3_tag),
        .prod      (prod),
        .bias      (bias_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    assign result_valid = res_valid;
    assign result       = res;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `RCV_ASSERT_HOLD(a_pos_range, (pos_col_reg <= COL_LAST) && (pos_row_reg <= ROW_LAST))
    `RCV_ASSERT_NEXT(a_frame_restart, pix_accept && item.frame_end, (pos_col_reg == '0) && (pos_row_reg == '0))
    `RCV_ASSERT_NEXT(a_weight_keeps_pos, item_accept && (item.opcode == OP_WEIGHT), $stable(pos_col_reg) && $stable(pos_row_reg))

endmodule
